// ===== src/usms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usms_pkg
// Shared types and codes for the ungapped segment match scorer.
// ----------------------------------------------------------------------------
package usms_pkg;

	localparam int BASE_W    = 8;
	localparam int ACTION_W  = 2;
	localparam int MATCH_W   = 4;
	localparam int MISS_W    = 5;
	localparam int CFG_W     = 5;
	localparam int RESULT_W  = 12;
	localparam logic [RESULT_W-1:0] RESULT_MAX = 12'd4095;

	localparam logic [ACTION_W-1:0] ACT_FIRST  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SECOND = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RUN    = 2'd2;

	localparam logic REG_MATCH    = 1'b0;
	localparam logic REG_MISMATCH = 1'b1;

	localparam logic [MATCH_W-1:0] MATCH_RST = 4'd2;
	localparam logic [MISS_W-1:0]  MISS_RST  = 5'h1F;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	// second-sequence character moving down the cell row
	typedef struct packed {
		logic              vld;
		logic [BASE_W-1:0] base;
	} link_t;

endpackage

// ===== src/usms_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usms_cell
// One cell of the scoring row: holds one first-sequence base, extends the
// diagonal run score passing through it and keeps the running best.
// ----------------------------------------------------------------------------
module usms_cell
	import usms_pkg::*;
#(
	parameter int IDX = 0,
	parameter int LW  = 9,
	parameter int SW  = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [BASE_W-1:0]        wr_base,
	input  logic [LW-1:0]            first_len,
	input  logic [MATCH_W-1:0]       match_score,
	input  logic signed [MISS_W-1:0] mismatch_score,
	input  link_t                    b_in,
	input  logic [SW-1:0]            h_in,
	input  logic [SW-1:0]            best_in,
	output link_t                    b_out,
	output logic [SW-1:0]            h_out,
	output logic [SW-1:0]            best_out
);

	logic [BASE_W-1:0]     a_q;
	link_t                 b_q;
	logic [SW-1:0]         h_s1, h_s2, best_s1, best_s2;
	logic                  pair_vld;
	logic signed [SW+1:0]  step, sum;
	logic [SW-1:0]         h_new, best_new;

	always_ff @(posedge clk) begin
		if (wr_en && first_len == LW'(IDX)) begin
			a_q <= wr_base;
		end
	end

	always_comb begin
		pair_vld = b_in.vld && (LW'(IDX) < first_len);
		if (a_q == b_in.base) begin
			step = $signed({{(SW-2){1'b0}}, match_score});
		end else begin
			step = $signed({{(SW-3){mismatch_score[MISS_W-1]}}, mismatch_score});
		end
		sum = $signed({2'b00, h_in}) + step;
		// clamp at zero: a local run restarts
		if (!pair_vld || sum < 0) begin
			h_new = '0;
		end else begin
			h_new = sum[SW-1:0];
		end
		best_new = (h_new > best_in) ? h_new : best_in;
	end

	// b advances one cell a cycle, the score through h_s1 and h_s2 in each cell, so each
	// score meets the next base of its diagonal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q     <= '0;
			h_s1    <= '0;
			h_s2    <= '0;
			best_s1 <= '0;
			best_s2 <= '0;
		end else begin
			b_q     <= b_in;
			h_s1    <= h_new;
			h_s2    <= h_s1;
			best_s1 <= best_new;
			best_s2 <= best_s1;
		end
	end

	assign b_out    = b_q;
	assign h_out    = h_s2;
	assign best_out = best_s2;

endmodule

// ===== src/ungapped_segment_match_score.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ungapped_segment_match_score
// Loads two base sequences and scores the best ungapped local alignment
// between them on a row of MAX_LEN cells.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  in       in_valid / in_stall   action, base
//  out      out_valid / out_stall best_score, overflow
//  cfg      cfg_wr_en             cfg_index, cfg_data
//
// Appends are accepted back to back.
// A run holds in_stall while the second sequence is read from its store
// one base a cycle into the cell row and the diagonal scores drain through
// the row.
// The result sits in an output register; appends are taken while it waits.
// A run finishes only when the output register is free.
// Reset clears lengths, flag, valid bit and the cell row's links and scores.
//
module ungapped_segment_match_score
	import usms_pkg::*;
#(
	parameter int MAX_LEN = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ACTION_W-1:0]   action,
	input  logic [BASE_W-1:0]     base,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [RESULT_W-1:0]   best_score,
	output logic                  overflow,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int LW    = $clog2(MAX_LEN + 1);
	localparam int AW    = $clog2(MAX_LEN);
	localparam int SW    = $clog2(15 * MAX_LEN + 1);
	localparam int EW    = (SW > RESULT_W) ? SW : RESULT_W;
	localparam int TOTAL = 4 * MAX_LEN + 2;
	localparam int CW    = $clog2(TOTAL);

	state_t                  state_q, state_d;
	logic                    in_acc, run_done, run_start;
	logic [CW-1:0]           cnt_q, rel;
	logic [LW-1:0]           first_len_q, second_len_q;
	logic                    dropped_q;
	logic [MATCH_W-1:0]      match_q;
	logic signed [MISS_W-1:0] miss_q;
	logic [BASE_W-1:0]       second_mem [MAX_LEN];
	logic                    rd_en;
	link_t                   feed_s1;
	logic                    a_wr;
	logic [SW-1:0]           best_all_q, best_fin;
	logic [EW-1:0]           best_ext;
	logic                    out_valid_q, overflow_q;
	logic [RESULT_W-1:0]     best_score_q;

	link_t                   link  [MAX_LEN+1];
	logic [SW-1:0]           hch   [MAX_LEN+1];
	logic [SW-1:0]           bch   [MAX_LEN+1];

	assign in_acc    = in_valid && !in_stall;
	assign run_start = in_acc && action == ACT_RUN;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= MATCH_RST;
			miss_q  <= MISS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MATCH:    match_q <= cfg_data[MATCH_W-1:0];
				REG_MISMATCH: miss_q  <= cfg_data[MISS_W-1:0];
				default:      ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b0;
		run_done = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (run_start) begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				in_stall = 1'b1;
				if (cnt_q == CW'(TOTAL - 1) && (!out_valid_q || !out_stall)) begin
					run_done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (run_start) begin
			cnt_q <= '0;
		end else if (state_q == S_RUN && cnt_q != CW'(TOTAL - 1)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// lengths and drop flag
	assign a_wr = in_acc && action == ACT_FIRST && first_len_q != LW'(MAX_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			dropped_q    <= 1'b0;
		end else if (run_done) begin
			first_len_q  <= '0;
			second_len_q <= '0;
			dropped_q    <= 1'b0;
		end else if (in_acc) begin
			case (action)
				ACT_FIRST: begin
					if (first_len_q != LW'(MAX_LEN)) begin
						first_len_q <= first_len_q + 1'b1;
					end else begin
						dropped_q <= 1'b1;
					end
				end
				ACT_SECOND: begin
					if (second_len_q != LW'(MAX_LEN)) begin
						second_len_q <= second_len_q + 1'b1;
					end else begin
						dropped_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// second store: stream base (cnt - (MAX_LEN-1)) into the row
	assign rel   = cnt_q - CW'(MAX_LEN - 1);
	assign rd_en = state_q == S_RUN && cnt_q >= CW'(MAX_LEN - 1)
		&& rel < CW'(second_len_q);

	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_SECOND && second_len_q != LW'(MAX_LEN)) begin
			second_mem[second_len_q[AW-1:0]] <= base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_s1 <= '0;
		end else begin
			feed_s1.vld  <= rd_en;
			feed_s1.base <= second_mem[rel[AW-1:0]];
		end
	end

	// cell row
	assign link[0] = feed_s1;
	assign hch[0]  = '0;
	assign bch[0]  = '0;

	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		usms_cell #(
			.IDX (i),
			.LW  (LW),
			.SW  (SW)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.wr_en          (a_wr),
			.wr_base        (base),
			.first_len      (first_len_q),
			.match_score    (match_q),
			.mismatch_score (miss_q),
			.b_in           (link[i]),
			.h_in           (hch[i]),
			.best_in        (bch[i]),
			.b_out          (link[i+1]),
			.h_out          (hch[i+1]),
			.best_out       (bch[i+1])
		);
	end

	// collect the best over all diagonals leaving the row
	assign best_fin = (bch[MAX_LEN] > best_all_q) ? bch[MAX_LEN] : best_all_q;
	assign best_ext = EW'(best_fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_all_q <= '0;
		end else if (run_start) begin
			best_all_q <= '0;
		end else if (state_q == S_RUN) begin
			best_all_q <= best_fin;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (run_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run_done) begin
			best_score_q <= (best_ext > EW'(RESULT_MAX)) ? RESULT_MAX
				: best_ext[RESULT_W-1:0];
			overflow_q   <= dropped_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_score = best_score_q;
	assign overflow   = overflow_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		first_len_q <= LW'(MAX_LEN) && second_len_q <= LW'(MAX_LEN))
		else $error("sequence length beyond capacity");

	a_run_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> in_stall)
		else $error("input taken during a run");

	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_RUN))
		else $error("result raised outside a run");

	a_lengths_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		run_done |=> first_len_q == '0 && second_len_q == '0 && !dropped_q)
		else $error("lengths not cleared after run");
`endif

endmodule
